### rtl/hcpu_pkg.sv
// Shared types, opcode encodings and decode helpers for the Harvard CPU step core.
`timescale 1ns / 1ps

package hcpu_pkg;

  typedef enum logic [2:0] {
    OP_LD    = 3'd0,
    OP_AND   = 3'd1,
    OP_OR    = 3'd2,
    OP_XOR   = 3'd3,
    OP_ADD   = 3'd4,
    OP_SUB   = 3'd5,
    OP_STORE = 3'd6,
    OP_JUMP  = 3'd7
  } alu_op_t;

  typedef enum logic [1:0] {
    SRC_D    = 2'd0,
    SRC_RAM  = 2'd1,
    SRC_AC   = 2'd2,
    SRC_IN   = 2'd3
  } bus_src_t;

  typedef enum logic [2:0] {
    DEST_NONE = 3'd0,
    DEST_AC   = 3'd1,
    DEST_X    = 3'd2,
    DEST_Y    = 3'd3,
    DEST_OUT  = 3'd4
  } dest_t;

  // Addressing modes (bits 4..2 of the instruction byte).
  localparam logic [2:0] MODE_D_AC    = 3'd0;
  localparam logic [2:0] MODE_X_AC    = 3'd1;
  localparam logic [2:0] MODE_YD_AC   = 3'd2;
  localparam logic [2:0] MODE_YX_AC   = 3'd3;
  localparam logic [2:0] MODE_D_X     = 3'd4;
  localparam logic [2:0] MODE_D_Y     = 3'd5;
  localparam logic [2:0] MODE_D_OUT   = 3'd6;
  localparam logic [2:0] MODE_YXI_OUT = 3'd7;

  localparam logic [15:0] PAGE_MASK = 16'hff00;

  typedef struct packed {
    logic [7:0] inst_byte;
    logic [7:0] data_byte;
    logic [7:0] in_port;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_fetch_addr;
    logic [7:0]  out_reg;
    logic [7:0]  acc;
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;
    logic        mem_write;
    logic [14:0] mem_write_addr;
    logic [7:0]  mem_write_data;
  } out_item_t;

  // Unreduced 16-bit data address {hi, lo} that an instruction byte selects.
  function automatic logic [15:0] data_addr(input logic [7:0] ir, input logic [7:0] d,
                                            input logic [7:0] x, input logic [7:0] y);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = 8'd0;
    lo = d;
    if (ir[7:5] != OP_JUMP) begin
      unique case (ir[4:2])
        MODE_X_AC: lo = x;
        MODE_YD_AC: hi = y;
        MODE_YX_AC, MODE_YXI_OUT: begin
          lo = x;
          hi = y;
        end
        default: ;
      endcase
    end
    return {hi, lo};
  endfunction

endpackage

### rtl/harvard_cpu_cycle_step_core.sv
// Top level: one clock tick of an eight-bit Harvard CPU per accepted transaction.
`timescale 1ns / 1ps

// Each input transaction is one machine tick: it carries the program word fetched at the
// previous next_fetch_addr and the input port byte. The core executes the instruction
// latched on the tick before, latches the new word and returns one result transaction
// with the new program counter, the visible registers and any data RAM write. Ticks may
// follow in every cycle while in_ready is high: the data RAM read for the next tick is
// issued at the edge that accepts the current one, so its registered data is ready when
// that tick executes, and a store to that same address is forwarded. Results leave through an
// output register backed by one skid entry, so in_ready drops only while both are full.
// The data RAM has no clearing pass; reading a location never written returns garbage.
module harvard_cpu_cycle_step_core #(
  parameter int RAM_WORDS = 32768
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcpu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcpu_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  localparam int AW = $clog2(RAM_WORDS);
  localparam int SW = AW + 1;

  // Constant function: (page * 256) mod RAM_WORDS by repeated reduction.
  function automatic logic [AW-1:0] page_base(input int page);
    int sum;
    sum = 0;
    for (int i = 0; i < page; i++) begin
      sum = sum + 256;
      if (sum >= RAM_WORDS) begin
        sum = sum - RAM_WORDS;
      end
    end
    return AW'(sum);
  endfunction

  logic [AW-1:0] page_mod [256];

  for (genvar g = 0; g < 256; g++) begin : g_page
    assign page_mod[g] = page_base(g);
  end

  // Architectural state.
  logic [15:0] pc_r;
  logic [7:0]  ir_r, d_r, ac_r, x_r, y_r, outl_r, undef_r;
  logic [15:0] pc_nxt;
  logic [7:0]  ac_nxt, x_nxt, y_nxt, outl_nxt;

  // RAM read address of the tick now latched, and store forwarding.
  logic [AW-1:0] rd_addr_r;
  logic          byp_valid_r;
  logic [7:0]    byp_data_r;

  logic          accept;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] addr_nxt;
  logic [15:0]   raw_nxt;
  logic [SW-1:0] sum_nxt;

  hcpu_pkg::alu_op_t  op;
  hcpu_pkg::bus_src_t src;
  hcpu_pkg::dest_t    dest;
  logic [2:0]  mode;
  logic        is_store, is_jump, inc_x, taken;
  logic [7:0]  bus, alu;
  logic [15:0] wr_addr16;
  hcpu_pkg::out_item_t res;

  // Output register and skid entry.
  logic                out_valid_r, skid_valid_r;
  hcpu_pkg::out_item_t out_data_r, skid_data_r;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Execute the latched instruction.
  always_comb begin
    op       = hcpu_pkg::alu_op_t'(ir_r[7:5]);
    mode     = ir_r[4:2];
    src      = hcpu_pkg::bus_src_t'(ir_r[1:0]);
    is_store = (op == hcpu_pkg::OP_STORE);
    is_jump  = (op == hcpu_pkg::OP_JUMP);
    dest     = hcpu_pkg::DEST_NONE;
    inc_x    = 1'b0;

    if (!is_jump) begin
      unique case (mode)
        hcpu_pkg::MODE_D_AC, hcpu_pkg::MODE_X_AC,
        hcpu_pkg::MODE_YD_AC, hcpu_pkg::MODE_YX_AC: dest = hcpu_pkg::DEST_AC;
        hcpu_pkg::MODE_D_X:   dest = hcpu_pkg::DEST_X;
        hcpu_pkg::MODE_D_Y:   dest = hcpu_pkg::DEST_Y;
        hcpu_pkg::MODE_D_OUT: dest = hcpu_pkg::DEST_OUT;
        default: begin
          dest  = hcpu_pkg::DEST_OUT;
          inc_x = 1'b1;
        end
      endcase
      if (is_store && (dest == hcpu_pkg::DEST_AC || dest == hcpu_pkg::DEST_OUT)) begin
        dest = hcpu_pkg::DEST_NONE;
      end
    end

    unique case (src)
      hcpu_pkg::SRC_D:   bus = d_r;
      hcpu_pkg::SRC_RAM: bus = is_store ? undef_r : (byp_valid_r ? byp_data_r : ram_rdata);
      hcpu_pkg::SRC_AC:  bus = ac_r;
      default:           bus = in_data.in_port;
    endcase

    unique case (op)
      hcpu_pkg::OP_LD:  alu = bus;
      hcpu_pkg::OP_AND: alu = ac_r & bus;
      hcpu_pkg::OP_OR:  alu = ac_r | bus;
      hcpu_pkg::OP_XOR: alu = ac_r ^ bus;
      hcpu_pkg::OP_ADD: alu = ac_r + bus;
      hcpu_pkg::OP_SUB: alu = ac_r - bus;
      default:          alu = ac_r;
    endcase

    ac_nxt   = ac_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    outl_nxt = outl_r;
    unique case (dest)
      hcpu_pkg::DEST_AC:  ac_nxt   = alu;
      hcpu_pkg::DEST_X:   x_nxt    = alu;
      hcpu_pkg::DEST_Y:   y_nxt    = alu;
      hcpu_pkg::DEST_OUT: outl_nxt = alu;
      default: ;
    endcase
    if (inc_x) begin
      x_nxt = x_r + 8'd1;
    end

    // Branch condition: zero beats negative, otherwise positive.
    if (ac_r == 8'd0) begin
      taken = mode[2];
    end else if (ac_r[7]) begin
      taken = mode[1];
    end else begin
      taken = mode[0];
    end

    pc_nxt = pc_r + 16'd1;
    if (is_jump) begin
      if (mode == hcpu_pkg::MODE_D_AC) begin
        pc_nxt = {y_r, bus};
      end else if (taken) begin
        pc_nxt = (pc_r & hcpu_pkg::PAGE_MASK) | {8'd0, bus};
      end
    end

    wr_addr16 = 16'(rd_addr_r);

    res.next_fetch_addr = pc_nxt;
    res.out_reg         = outl_nxt;
    res.acc             = ac_nxt;
    res.x_reg           = x_nxt;
    res.y_reg           = y_nxt;
    res.mem_write       = is_store;
    res.mem_write_addr  = is_store ? wr_addr16[14:0] : 15'd0;
    res.mem_write_data  = is_store ? bus : 8'd0;
  end

  // Data address of the instruction being latched, reduced modulo the RAM size.
  always_comb begin
    raw_nxt = hcpu_pkg::data_addr(in_data.inst_byte, in_data.data_byte, x_nxt, y_nxt);
    sum_nxt = SW'(page_mod[raw_nxt[15:8]]) + SW'(raw_nxt[7:0]);
    if (sum_nxt >= SW'(RAM_WORDS)) begin
      sum_nxt = sum_nxt - SW'(RAM_WORDS);
    end
    addr_nxt = sum_nxt[AW-1:0];
  end

  assign ram_raddr = accept ? addr_nxt : rd_addr_r;

  hcpu_ram #(
    .WIDTH (8),
    .DEPTH (RAM_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept && is_store),
    .wr_addr (rd_addr_r),
    .wr_data (bus),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      ir_r        <= '0;
      d_r         <= '0;
      ac_r        <= '0;
      x_r         <= '0;
      y_r         <= '0;
      outl_r      <= '0;
      rd_addr_r   <= '0;
      byp_valid_r <= 1'b0;
    end else if (accept) begin
      pc_r        <= pc_nxt;
      ir_r        <= in_data.inst_byte;
      d_r         <= in_data.data_byte;
      ac_r        <= ac_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      outl_r      <= outl_nxt;
      rd_addr_r   <= addr_nxt;
      // The RAM returns the old byte when a store hits the address read at the same edge.
      byp_valid_r <= is_store && (addr_nxt == rd_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data_r <= bus;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      undef_r <= '0;
    end else if (cfg_wr_en) begin
      undef_r <= cfg_wr_data;
    end
  end

  // Output register with one skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (accept) begin
      if (out_valid_r && !out_ready) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

endmodule

### rtl/hcpu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module hcpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/hcpu_checker.sv
// Port-level assertions for the Harvard CPU step core, bound to the top level.
`timescale 1ns / 1ps

module hcpu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input hcpu_pkg::out_item_t out_data
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Every accepted tick is followed in the next cycle by a valid result at the output.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  // Backpressure on the input only while a result is held at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // A result without a RAM write reports a zero address and data.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mem_write |->
      out_data.mem_write_addr == 15'd0 && out_data.mem_write_data == 8'd0)
    else $error("write fields set without a RAM write");

  // Reset leaves the input side ready.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind harvard_cpu_cycle_step_core hcpu_checker u_hcpu_checker (.*);
